FILE: src/wsm_pkg.sv
// Shared types and constants for the window sum match counter.
// Used by every module of the block; depends on nothing else.
package wsm_pkg;

    localparam int WINDOW_DEPTH = 1024;
    localparam int VALUE_WIDTH  = 16;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
    localparam int LEN_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int SLOT_W       = ADDR_W + 1;
    localparam int SUM_W        = 32;
    localparam int TARGET_W     = 31;
    localparam int SEED_W       = 32;
    localparam int COUNT_W      = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SUM    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_VALUE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_SELECT = 2'd2;

    localparam logic [31:0] LCG_MUL   = 32'd214013;
    localparam logic [31:0] LCG_ADD   = 32'd2531011;
    localparam logic [31:0] LCG_MOD   = 32'd10000;
    localparam logic [31:0] LCG_RESET = 32'd1983;

    // The quotient estimate from this reciprocal is exact or one too small.
    localparam int          RECIP_SHIFT = 45;
    localparam logic [63:0] RECIP_MUL   = (64'd1 << RECIP_SHIFT) / 64'd10000;
    localparam int          QUOT_W      = 64 - RECIP_SHIFT;

    typedef struct packed {
        logic load;
        logic go;
    } gen_ctrl_t;

    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] value;
    } gen_stat_t;

    typedef struct packed {
        logic                   wr_en;
        logic [ADDR_W-1:0]      wr_addr;
        logic [VALUE_WIDTH-1:0] wr_data;
        logic                   rd_en;
        logic [ADDR_W-1:0]      rd_addr;
    } store_req_t;

endpackage

FILE: src/wsm_gen.sv
// Linear congruential generator reduced to 1..10000, in multiply, reduce and finish phases.
// Depends on wsm_pkg.
module wsm_gen import wsm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  gen_ctrl_t         ctrl,
    input  logic [SEED_W-1:0] seed,
    output gen_stat_t         stat
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_RED  = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;

    logic [1:0]             phase_reg;
    logic [31:0]            lcg_reg;
    logic [31:0]            work_reg;
    logic [QUOT_W-1:0]      quot_reg;
    logic [31:0]            step_reg;
    logic [31:0]            qm_reg;
    logic                   done_reg;
    logic [VALUE_WIDTH-1:0] value_reg;

    logic [31:0] cur_state;
    logic [63:0] recip_prod;
    logic [63:0] step_prod;
    logic [32:0] qm_prod;
    logic [31:0] rem_raw;
    logic [31:0] rem_fix;

    assign cur_state  = ctrl.load ? seed : lcg_reg;
    assign recip_prod = {32'd0, work_reg} * RECIP_MUL;
    assign step_prod  = {32'd0, work_reg} * {32'd0, LCG_MUL};
    assign qm_prod    = {14'd0, quot_reg} * 33'(LCG_MOD);
    assign rem_raw    = work_reg - qm_reg;
    assign rem_fix    = (rem_raw >= LCG_MOD) ? rem_raw - LCG_MOD : rem_raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            lcg_reg   <= LCG_RESET;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (phase_reg)
                PH_IDLE: begin
                    if (ctrl.load) begin
                        lcg_reg <= seed;
                    end
                    if (ctrl.go) begin
                        work_reg  <= cur_state;
                        phase_reg <= PH_MUL;
                    end
                end
                PH_MUL: begin
                    quot_reg  <= recip_prod[63:RECIP_SHIFT];
                    step_reg  <= step_prod[31:0];
                    phase_reg <= PH_RED;
                end
                PH_RED: begin
                    qm_reg    <= qm_prod[31:0];
                    lcg_reg   <= step_reg + LCG_ADD;
                    phase_reg <= PH_FIN;
                end
                PH_FIN: begin
                    value_reg <= rem_fix[VALUE_WIDTH-1:0] + 1'b1;
                    done_reg  <= 1'b1;
                    phase_reg <= PH_IDLE;
                end
                default: begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    assign stat.done  = done_reg;
    assign stat.value = value_reg;

endmodule

FILE: src/wsm_store.sv
// Window memory: one write port and one read port with registered read data.
// Depends on wsm_pkg.
module wsm_store import wsm_pkg::*; (
    input  logic                   aclk,
    input  store_req_t             req,
    output logic [VALUE_WIDTH-1:0] rd_data
);

    logic [VALUE_WIDTH-1:0] mem [WINDOW_DEPTH];
    logic [VALUE_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/window_sum_match_counter.sv
// Top level of the window sum match counter: control sequencer, window
// pointers, running sum, match count and result register.
// Depends on wsm_pkg, wsm_gen and wsm_store.
//
//   Channel  Direction  Handshake            Payload
//   s_       in         s_valid / s_ready    s_start_run, s_sample
//   m_       out        m_valid / m_ready    m_signal_value, m_window_sum,
//                                            m_is_match, m_match_count,
//                                            m_overflow
//   cfg_     in         cfg_write_en         cfg_index, cfg_data
//
// An item goes through the fetch, push, check and done states, after a
// generator wait with that source; a value forced out of a full window
// adds a subtract state and each pop a pop subtract and a check, paced
// by the registered memory read. One item is in work at a time, and a new
// item is taken while the previous result waits in the output register.
// Reset is synchronous; the window memory has no clearing pass since only
// entries that were written are read.
module window_sum_match_counter import wsm_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_start_run,
    input  logic [15:0]            s_sample,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [15:0]            m_signal_value,
    output logic [30:0]            m_window_sum,
    output logic                   m_is_match,
    output logic [31:0]            m_match_count,
    output logic                   m_overflow,
    input  logic                   cfg_write_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_GEN_WAIT = 3'd1;
    localparam logic [2:0] ST_FETCH    = 3'd2;
    localparam logic [2:0] ST_FULL_SUB = 3'd3;
    localparam logic [2:0] ST_PUSH     = 3'd4;
    localparam logic [2:0] ST_CHECK    = 3'd5;
    localparam logic [2:0] ST_POP_SUB  = 3'd6;
    localparam logic [2:0] ST_DONE     = 3'd7;

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic [TARGET_W-1:0]    target_reg;
    logic [SEED_W-1:0]      seed_reg;
    logic                   source_reg;
    logic [ADDR_W-1:0]      oldest_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [COUNT_W-1:0]     matches_reg;
    logic                   ovf_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic                   out_valid_reg;
    logic [15:0]            out_value_reg;
    logic [30:0]            out_sum_reg;
    logic                   out_match_reg;
    logic [31:0]            out_count_reg;
    logic                   out_ovf_reg;

    gen_ctrl_t              gen_ctrl;
    gen_stat_t              gen_stat;
    store_req_t             store_req;
    logic [VALUE_WIDTH-1:0] rd_data;

    logic                   accept;
    logic                   out_free;
    logic                   hit;
    logic                   win_full;
    logic                   need_pop;
    logic [SLOT_W-1:0]      slot_raw;
    logic [SLOT_W-1:0]      slot_fix;
    logic [ADDR_W-1:0]      oldest_inc;

    assign accept     = s_valid && s_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign out_free   = !out_valid_reg || m_ready;
    assign hit        = (sum_reg == {1'b0, target_reg});
    assign win_full   = (len_reg == LEN_W'(WINDOW_DEPTH));
    assign need_pop   = (sum_reg > {1'b0, target_reg}) && (len_reg != '0);
    assign slot_raw   = {1'b0, oldest_reg} + SLOT_W'(len_reg);
    assign slot_fix   = (slot_raw >= SLOT_W'(WINDOW_DEPTH)) ?
                        slot_raw - SLOT_W'(WINDOW_DEPTH) : slot_raw;
    assign oldest_inc = (oldest_reg == ADDR_W'(WINDOW_DEPTH - 1)) ?
                        '0 : oldest_reg + 1'b1;

    assign gen_ctrl.load = accept && s_start_run;
    assign gen_ctrl.go   = accept && !source_reg;

    always_comb begin
        store_req.wr_en   = (state_reg == ST_PUSH);
        store_req.wr_addr = slot_fix[ADDR_W-1:0];
        store_req.wr_data = val_reg;
        store_req.rd_en   = ((state_reg == ST_FETCH) && win_full)
                            || ((state_reg == ST_CHECK) && need_pop);
        store_req.rd_addr = oldest_reg;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = source_reg ? ST_FETCH : ST_GEN_WAIT;
                end
            end
            ST_GEN_WAIT: begin
                if (gen_stat.done) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = win_full ? ST_FULL_SUB : ST_PUSH;
            end
            ST_FULL_SUB: begin
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = need_pop ? ST_POP_SUB : ST_DONE;
            end
            ST_POP_SUB: begin
                state_next = ST_CHECK;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
            seed_reg   <= LCG_RESET;
            source_reg <= 1'b0;
        end else if (cfg_write_en) begin
            case (cfg_index)
                REG_TARGET_SUM: begin
                    target_reg <= cfg_data[TARGET_W-1:0];
                end
                REG_SEED_VALUE: begin
                    seed_reg <= cfg_data[SEED_W-1:0];
                end
                REG_SOURCE_SELECT: begin
                    source_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            oldest_reg    <= '0;
            len_reg       <= '0;
            sum_reg       <= '0;
            matches_reg   <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == ST_DONE) && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        val_reg <= s_sample;
                        if (s_start_run) begin
                            oldest_reg  <= '0;
                            len_reg     <= '0;
                            sum_reg     <= '0;
                            matches_reg <= '0;
                            ovf_reg     <= 1'b0;
                        end
                    end
                end
                ST_GEN_WAIT: begin
                    if (gen_stat.done) begin
                        val_reg <= gen_stat.value;
                    end
                end
                ST_FULL_SUB, ST_POP_SUB: begin
                    sum_reg    <= sum_reg - SUM_W'(rd_data);
                    oldest_reg <= oldest_inc;
                    len_reg    <= len_reg - 1'b1;
                    if (state_reg == ST_FULL_SUB) begin
                        ovf_reg <= 1'b1;
                    end
                end
                ST_PUSH: begin
                    sum_reg <= sum_reg + SUM_W'(val_reg);
                    len_reg <= len_reg + 1'b1;
                end
                ST_DONE: begin
                    if (out_free) begin
                        out_value_reg <= val_reg;
                        out_sum_reg   <= sum_reg[30:0];
                        out_match_reg <= hit;
                        out_ovf_reg   <= ovf_reg;
                        if (hit && (matches_reg != '1)) begin
                            matches_reg   <= matches_reg + 1'b1;
                            out_count_reg <= matches_reg + 1'b1;
                        end else begin
                            out_count_reg <= matches_reg;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    wsm_gen u_gen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (gen_ctrl),
        .seed    (seed_reg),
        .stat    (gen_stat)
    );

    wsm_store u_store (
        .aclk    (aclk),
        .req     (store_req),
        .rd_data (rd_data)
    );

    assign m_valid        = out_valid_reg;
    assign m_signal_value = out_value_reg;
    assign m_window_sum   = out_sum_reg;
    assign m_is_match     = out_match_reg;
    assign m_match_count  = out_count_reg;
    assign m_overflow     = out_ovf_reg;

`ifndef SYNTHESIS
    a_len_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(WINDOW_DEPTH))
        else $error("window length exceeds depth");

    a_gen_only_when_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        gen_stat.done |-> (state_reg == ST_GEN_WAIT))
        else $error("generator result arrived outside its wait state");

    a_match_equals_target: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_match) |-> (m_window_sum == target_reg))
        else $error("match flagged with window sum off target");

    a_sum_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> (sum_reg <= {1'b0, target_reg}))
        else $error("window sum above target at item end");
`endif

endmodule
